// ===== sv/route_transposition_cipher_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the route transposition cipher
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ROUTE_TRANSPOSITION_CIPHER_ASSERT_SVH
`define ROUTE_TRANSPOSITION_CIPHER_ASSERT_SVH

// same-cycle implication
`define RTC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rtc_pkg.sv =====
// ---------------------------------------------------------------------------
// rtc_pkg
// Shared constants, codes and types of the route transposition cipher.
// ---------------------------------------------------------------------------
package rtc_pkg;

    localparam int MAX_LETTERS = 64;
    localparam int AW          = $clog2(MAX_LETTERS);
    localparam int CW          = $clog2(MAX_LETTERS + 1);
    localparam int PW          = CW + 1;
    localparam int COL_W       = 7;
    localparam int CMPW        = (CW > COL_W) ? CW : COL_W;
    localparam int CODE_W      = 5;
    localparam int LETTER_W    = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int QDEPTH      = 2;
    localparam int QPW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd65;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // one finished message as handed from front to back
    typedef struct packed {
        status_t         status;
        logic [CW-1:0]   n;
        logic [CW-1:0]   cols;
        logic            decrypt;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ===== sv/route_transposition_cipher.sv =====
// ---------------------------------------------------------------------------
// route_transposition_cipher: one byte per cycle in while busy is low.
// An error message gives a single zero result; an ok message is copied
// from the store to scratch in route order, then emitted one letter a cycle.
// After an ok message, busy holds new messages until its store copy ends.
// Reset: 1 column, encrypt, empty message; RAMs are not cleared.
// ---------------------------------------------------------------------------
module route_transposition_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    output logic                            busy,
    input  logic                            cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtc_pkg::COL_W-1:0]       cfg_data,
    output logic                            result_valid,
    output logic [rtc_pkg::LETTER_W-1:0]    out_letter,
    output logic                            out_last,
    output logic [1:0]                      status
);

    rtc_pkg::q_stat_t           q_stat;
    rtc_pkg::job_t              push_job;
    rtc_pkg::job_t              head_job;
    logic                       q_push;
    logic                       q_pop;
    logic                       store_we;
    logic [rtc_pkg::AW-1:0]     store_waddr;
    logic [rtc_pkg::CODE_W-1:0] store_wdata;
    logic [rtc_pkg::AW-1:0]     store_raddr;
    logic [rtc_pkg::CODE_W-1:0] store_rdata;
    logic                       store_free;

    rtc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_job       (push_job),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .store_free  (store_free)
    );

    rtc_ram #(
        .WIDTH (rtc_pkg::CODE_W),
        .DEPTH (rtc_pkg::MAX_LETTERS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    rtc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .stat     (q_stat)
    );

    rtc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .store_raddr  (store_raddr),
        .store_rdata  (store_rdata),
        .store_free   (store_free),
        .result_valid (result_valid),
        .out_letter   (out_letter),
        .out_last     (out_last),
        .status       (status)
    );

`include "route_transposition_cipher_assert.svh"

    `RTC_ASSERT_IMP(a_queue_no_overrun, q_push, !q_stat.full, "request pushed into full queue")
    `RTC_ASSERT_IMP(a_error_single, result_valid && (status != rtc_pkg::ST_OK), out_last && (out_letter == '0), "error result not a lone zero result")
    `RTC_ASSERT_IMP(a_letter_range, result_valid && (status == rtc_pkg::ST_OK), (out_letter >= rtc_pkg::LETTER_BASE) && (out_letter <= 7'd90), "ok result is not a capital letter")
    `RTC_ASSERT_NEXT(a_free_unlocks, store_free, busy == q_stat.full, "store release lost")

endmodule

// ===== sv/rtc_ram.sv =====
// ---------------------------------------------------------------------------
// rtc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rtc_front.sv =====
// ---------------------------------------------------------------------------
// rtc_front
// Accepts message bytes, keeps letters in the store and classifies each
// finished message into an ok or error request for the back end.
// ---------------------------------------------------------------------------
module rtc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    output logic                               busy,
    input  logic                               cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtc_pkg::COL_W-1:0]          cfg_data,
    input  rtc_pkg::q_stat_t                   q_stat,
    output logic                               q_push,
    output rtc_pkg::job_t                      q_job,
    output logic                               store_we,
    output logic [rtc_pkg::AW-1:0]             store_waddr,
    output logic [rtc_pkg::CODE_W-1:0]         store_wdata,
    input  logic                               store_free
);

    logic [rtc_pkg::COL_W-1:0] column_count_reg, column_count_next;
    logic                      decrypt_mode_reg, decrypt_mode_next;
    logic [rtc_pkg::CW-1:0]    count_reg, count_next;
    logic                      overflow_reg, overflow_next;
    logic                      lock_reg, lock_next;

    logic                      accept;
    logic                      is_upper;
    logic                      is_lower;
    logic                      is_letter;
    logic                      have_room;
    logic [rtc_pkg::CW-1:0]    n_final;
    logic                      ovf_final;
    logic [rtc_pkg::COL_W-1:0] cols_eff;
    rtc_pkg::status_t          err;

    assign busy      = lock_reg || q_stat.full;
    assign accept    = start && !busy;
    assign is_upper  = (in_byte >= rtc_pkg::UPPER_A) && (in_byte <= rtc_pkg::UPPER_Z);
    assign is_lower  = (in_byte >= rtc_pkg::LOWER_A) && (in_byte <= rtc_pkg::LOWER_Z);
    assign is_letter = is_upper || is_lower;
    assign have_room = count_reg != rtc_pkg::CW'(rtc_pkg::MAX_LETTERS);

    assign store_we    = accept && is_letter && have_room;
    assign store_waddr = count_reg[rtc_pkg::AW-1:0];
    assign store_wdata = is_upper ? rtc_pkg::CODE_W'(in_byte - rtc_pkg::UPPER_A)
                                  : rtc_pkg::CODE_W'(in_byte - rtc_pkg::LOWER_A);

    assign n_final   = store_we ? count_reg + rtc_pkg::CW'(1) : count_reg;
    assign ovf_final = overflow_reg || (accept && is_letter && !have_room);
    // a key of zero columns acts as one
    assign cols_eff  = (column_count_reg == '0) ? rtc_pkg::COL_W'(1) : column_count_reg;

    always_comb
    begin
        if (n_final == '0)
        begin
            err = rtc_pkg::ST_EMPTY;
        end
        else if (ovf_final)
        begin
            err = rtc_pkg::ST_OVERFLOW;
        end
        else if (rtc_pkg::CMPW'(n_final) <= rtc_pkg::CMPW'(cols_eff))
        begin
            err = rtc_pkg::ST_SHORT;
        end
        else
        begin
            err = rtc_pkg::ST_OK;
        end
    end

    assign q_push        = accept && in_last;
    assign q_job.status  = err;
    assign q_job.n       = n_final;
    // ok requests have fewer columns than letters, so this cut is lossless
    assign q_job.cols    = rtc_pkg::CW'(cols_eff);
    assign q_job.decrypt = decrypt_mode_reg;

    always_comb
    begin
        column_count_next = column_count_reg;
        decrypt_mode_next = decrypt_mode_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        lock_next         = lock_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rtc_pkg::REG_COLUMN_COUNT: column_count_next = cfg_data;
                rtc_pkg::REG_DECRYPT_MODE: decrypt_mode_next = cfg_data[0];
                default: ;
            endcase
        end

        if (accept)
        begin
            if (in_last)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
            else
            begin
                count_next    = n_final;
                overflow_next = ovf_final;
            end
        end

        // hold the store until the back end has copied it out
        if (store_free)
        begin
            lock_next = 1'b0;
        end
        if (q_push && (err == rtc_pkg::ST_OK))
        begin
            lock_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= rtc_pkg::COL_W'(1);
            decrypt_mode_reg <= 1'b0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            lock_reg         <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            decrypt_mode_reg <= decrypt_mode_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            lock_reg         <= lock_next;
        end
    end

endmodule

// ===== sv/rtc_queue.sv =====
// ---------------------------------------------------------------------------
// rtc_queue
// Short request queue between front and back end.
// ---------------------------------------------------------------------------
module rtc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rtc_pkg::job_t    push_job,
    input  logic             pop,
    output rtc_pkg::job_t    head,
    output rtc_pkg::q_stat_t stat
);

    rtc_pkg::job_t           entry_reg [rtc_pkg::QDEPTH];
    logic [rtc_pkg::QPW-1:0] wptr_reg, wptr_next;
    logic [rtc_pkg::QPW-1:0] rptr_reg, rptr_next;
    logic [rtc_pkg::QCW-1:0] cnt_reg, cnt_next;
    logic                    do_push;
    logic                    do_pop;

    assign stat.empty = cnt_reg == '0;
    assign stat.full  = cnt_reg == rtc_pkg::QCW'(rtc_pkg::QDEPTH);
    assign head       = entry_reg[rptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == rtc_pkg::QPW'(rtc_pkg::QDEPTH - 1))
                        ? '0 : wptr_reg + rtc_pkg::QPW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == rtc_pkg::QPW'(rtc_pkg::QDEPTH - 1))
                        ? '0 : rptr_reg + rtc_pkg::QPW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + rtc_pkg::QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - rtc_pkg::QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/rtc_back.sv =====
// ---------------------------------------------------------------------------
// rtc_back
// Carries out queued requests: copies the store into the scratch RAM in
// route order, then emits the scratch RAM in order, or emits one error.
// ---------------------------------------------------------------------------
module rtc_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rtc_pkg::q_stat_t                 q_stat,
    input  rtc_pkg::job_t                    q_head,
    output logic                             q_pop,
    output logic [rtc_pkg::AW-1:0]           store_raddr,
    input  logic [rtc_pkg::CODE_W-1:0]       store_rdata,
    output logic                             store_free,
    output logic                             result_valid,
    output logic [rtc_pkg::LETTER_W-1:0]     out_letter,
    output logic                             out_last,
    output logic [1:0]                       status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PERM,
        S_DRAIN,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    rtc_pkg::job_t          job_reg, job_next;
    logic [rtc_pkg::CW-1:0] k_reg, k_next;
    logic [rtc_pkg::PW-1:0] pos_reg, pos_next;
    logic [rtc_pkg::CW-1:0] col_reg, col_next;
    logic [rtc_pkg::CW-1:0] t_reg, t_next;
    logic                   wpend_reg, wpend_next;
    logic [rtc_pkg::AW-1:0] waddr_reg, waddr_next;
    logic                   free_reg, free_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_ram_reg, res_ram_next;
    logic                   res_last_reg, res_last_next;
    rtc_pkg::status_t       res_status_reg, res_status_next;

    logic [rtc_pkg::PW-1:0]     pos_step;
    logic [rtc_pkg::CW-1:0]     col_dec;
    logic [rtc_pkg::CW-1:0]     n_dec;
    logic [rtc_pkg::CODE_W-1:0] scr_rdata;

    assign pos_step = pos_reg + rtc_pkg::PW'(job_reg.cols);
    assign col_dec  = col_reg - rtc_pkg::CW'(1);
    assign n_dec    = job_reg.n - rtc_pkg::CW'(1);

    // encrypt gathers from the route, decrypt scatters onto it
    assign store_raddr = job_reg.decrypt ? k_reg[rtc_pkg::AW-1:0]
                                         : pos_reg[rtc_pkg::AW-1:0];

    rtc_ram #(
        .WIDTH (rtc_pkg::CODE_W),
        .DEPTH (rtc_pkg::MAX_LETTERS)
    ) u_scratch (
        .clk   (clk),
        .we    (wpend_reg),
        .waddr (waddr_reg),
        .wdata (store_rdata),
        .raddr (t_reg[rtc_pkg::AW-1:0]),
        .rdata (scr_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        col_next        = col_reg;
        t_next          = t_reg;
        wpend_next      = 1'b0;
        waddr_next      = waddr_reg;
        free_next       = 1'b0;
        res_valid_next  = 1'b0;
        res_ram_next    = res_ram_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.status != rtc_pkg::ST_OK)
                    begin
                        res_valid_next  = 1'b1;
                        res_ram_next    = 1'b0;
                        res_last_next   = 1'b1;
                        res_status_next = q_head.status;
                    end
                    else
                    begin
                        job_next   = q_head;
                        k_next     = '0;
                        col_next   = q_head.cols - rtc_pkg::CW'(1);
                        pos_next   = rtc_pkg::PW'(q_head.cols) - rtc_pkg::PW'(1);
                        state_next = S_PERM;
                    end
                end
            end

            S_PERM:
            begin
                wpend_next = 1'b1;
                waddr_next = job_reg.decrypt ? pos_reg[rtc_pkg::AW-1:0]
                                             : k_reg[rtc_pkg::AW-1:0];
                k_next     = k_reg + rtc_pkg::CW'(1);
                // drop to the next column to the left past the bottom row
                if (pos_step >= rtc_pkg::PW'(job_reg.n))
                begin
                    col_next = col_dec;
                    pos_next = rtc_pkg::PW'(col_dec);
                end
                else
                begin
                    pos_next = pos_step;
                end
                if (k_reg == n_dec)
                begin
                    free_next  = 1'b1;
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                t_next     = '0;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                res_valid_next  = 1'b1;
                res_ram_next    = 1'b1;
                res_last_next   = t_reg == n_dec;
                res_status_next = rtc_pkg::ST_OK;
                t_next          = t_reg + rtc_pkg::CW'(1);
                if (t_reg == n_dec)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= '0;
            k_reg          <= '0;
            pos_reg        <= '0;
            col_reg        <= '0;
            t_reg          <= '0;
            wpend_reg      <= 1'b0;
            waddr_reg      <= '0;
            free_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_ram_reg    <= 1'b0;
            res_last_reg   <= 1'b0;
            res_status_reg <= rtc_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            k_reg          <= k_next;
            pos_reg        <= pos_next;
            col_reg        <= col_next;
            t_reg          <= t_next;
            wpend_reg      <= wpend_next;
            waddr_reg      <= waddr_next;
            free_reg       <= free_next;
            res_valid_reg  <= res_valid_next;
            res_ram_reg    <= res_ram_next;
            res_last_reg   <= res_last_next;
            res_status_reg <= res_status_next;
        end
    end

    assign store_free   = free_reg;
    assign result_valid = res_valid_reg;
    assign out_letter   = res_ram_reg ? rtc_pkg::LETTER_W'(scr_rdata) + rtc_pkg::LETTER_BASE
                                      : '0;
    assign out_last     = res_last_reg;
    assign status       = res_status_reg;

endmodule

// ===== sim/route_transposition_cipher_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// route_transposition_cipher_tb
// Self-checking bench: feeds message bytes through the start/busy handshake,
// predicts every result strobe from a local model of the cipher and checks
// letter, last flag and status in order. Covers encrypt and decrypt, every
// error status, column extremes and random idle gaps.
// ---------------------------------------------------------------------------
module route_transposition_cipher_tb;

    localparam int ITEM_TARGET    = 220;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_TAIL     = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [rtc_pkg::LETTER_W-1:0] letter;
        logic                         last;
        rtc_pkg::status_t             status;
    } cipher_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic [7:0]                    in_byte   = 8'd0;
    logic                          in_last   = 1'b0;
    logic                          busy;
    logic                          cfg_we    = 1'b0;
    logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index = rtc_pkg::REG_COLUMN_COUNT;
    logic [rtc_pkg::COL_W-1:0]     cfg_data  = '0;
    logic                          result_valid;
    logic [rtc_pkg::LETTER_W-1:0]  out_letter;
    logic                          out_last;
    logic [1:0]                    status;

    // model of the block
    logic [rtc_pkg::COL_W-1:0]     key_columns;
    logic                          decrypting;
    logic [rtc_pkg::CODE_W-1:0]    held_letters [rtc_pkg::MAX_LETTERS];
    int                            held_count;
    logic                          store_overrun;

    cipher_result_t       awaited_results [$];
    cipher_result_t       oldest;

    int fail_count      = 0;
    int results_checked = 0;
    int bytes_sent      = 0;
    int settings_used   = 0;
    int status_tally [4];
    int idle_cycles     = 0;
    bit pace_on         = 1'b0;

    route_transposition_cipher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .out_letter   (out_letter),
        .out_last     (out_last),
        .status       (status)
    );

    always #6 clk = ~clk;

    function automatic void reset_cipher_model();
        key_columns   = 7'd1;
        decrypting    = 1'b0;
        held_count    = 0;
        store_overrun = 1'b0;
        for (int s = 0; s < 4; s++)
            status_tally[s] = 0;
    endfunction

    // absorb one accepted byte; on the last byte queue the transposed letters
    function automatic void take_message_byte(input logic [7:0] b, input logic l);
        logic [rtc_pkg::CODE_W-1:0] code;
        logic                       is_alpha;
        int                         n;
        int                         cols;
        int                         rows;
        int                         k;
        int                         pos;
        rtc_pkg::status_t           verdict;
        logic [rtc_pkg::CODE_W-1:0] order [rtc_pkg::MAX_LETTERS];
        cipher_result_t             r;
        is_alpha = 1'b0;
        code     = '0;
        if (b >= rtc_pkg::UPPER_A && b <= rtc_pkg::UPPER_Z)
        begin
            code     = rtc_pkg::CODE_W'(b - rtc_pkg::UPPER_A);
            is_alpha = 1'b1;
        end
        else if (b >= rtc_pkg::LOWER_A && b <= rtc_pkg::LOWER_Z)
        begin
            code     = rtc_pkg::CODE_W'(b - rtc_pkg::LOWER_A);
            is_alpha = 1'b1;
        end
        if (is_alpha)
        begin
            if (held_count < rtc_pkg::MAX_LETTERS)
            begin
                held_letters[held_count] = code;
                held_count++;
            end
            else
                store_overrun = 1'b1;
        end
        if (!l)
            return;

        n    = held_count;
        cols = (key_columns == 0) ? 1 : int'(key_columns);
        if (n == 0)
            verdict = rtc_pkg::ST_EMPTY;
        else if (store_overrun)
            verdict = rtc_pkg::ST_OVERFLOW;
        else if (n <= cols)
            verdict = rtc_pkg::ST_SHORT;
        else
            verdict = rtc_pkg::ST_OK;
        held_count    = 0;
        store_overrun = 1'b0;
        status_tally[verdict]++;

        if (verdict != rtc_pkg::ST_OK)
        begin
            r.letter = '0;
            r.last   = 1'b1;
            r.status = verdict;
            awaited_results.push_back(r);
            return;
        end

        // walk columns right to left, rows top to bottom, skipping empty cells
        rows = (n + cols - 1) / cols;
        k    = 0;
        for (int j = cols - 1; j >= 0; j--)
            for (int i = 0; i < rows; i++)
            begin
                pos = i * cols + j;
                if (pos < n)
                begin
                    if (decrypting)
                        order[pos] = held_letters[k];
                    else
                        order[k] = held_letters[pos];
                    k++;
                end
            end
        for (int t = 0; t < n; t++)
        begin
            r.letter = rtc_pkg::LETTER_BASE + rtc_pkg::LETTER_W'(order[t]);
            r.last   = (t == n - 1);
            r.status = rtc_pkg::ST_OK;
            awaited_results.push_back(r);
        end
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] code;
        code = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) != 0) ? rtc_pkg::UPPER_A + code
                                           : rtc_pkg::LOWER_A + code;
    endfunction

    function automatic logic [7:0] random_non_letter();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while ((v >= rtc_pkg::UPPER_A && v <= rtc_pkg::UPPER_Z) ||
               (v >= rtc_pkg::LOWER_A && v <= rtc_pkg::LOWER_Z));
        return v;
    endfunction

    // hold start high until the request is taken; lower it only before a gap
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pace_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_byte <= b;
        in_last <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_message_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], i == text.len() - 1);
    endtask

    task automatic send_message(input int n_letters, input int noise_pct);
        for (int i = 0; i < n_letters; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_byte(random_non_letter(), 1'b0);
            if (i == n_letters - 1 && $urandom_range(0, 1) != 0)
                send_byte(random_letter(), 1'b1);
            else
                send_byte(random_letter(), 1'b0);
        end
        if (n_letters == 0 || in_last == 1'b0)
            send_byte(random_non_letter(), 1'b1);
    endtask

    // drop start and hold until every queued result has come out
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic write_register(input logic [rtc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rtc_pkg::COL_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == rtc_pkg::REG_COLUMN_COUNT)
            key_columns = value;
        else
            decrypting = value[0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int cols, input bit decrypt);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(rtc_pkg::REG_COLUMN_COUNT, rtc_pkg::COL_W'(cols));
        write_register(rtc_pkg::REG_DECRYPT_MODE, rtc_pkg::COL_W'(decrypt));
        settings_used++;
    endtask

    task automatic test_reset_state();
        pace_on = 1'b0;
        send_text("Ab");
        send_text("x");
        send_text(" ");
    endtask

    task automatic test_encrypt_mixed_bytes();
        apply_setting(3, 1'b0);
        pace_on = 1'b1;
        send_byte("H", 1'b0);
        send_byte("e", 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte("L", 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte("l", 1'b0);
        send_byte(8'h60, 1'b0);
        send_byte("O", 1'b0);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte("z", 1'b0);
        send_byte("A", 1'b0);
        send_byte("Z", 1'b1);
    endtask

    task automatic test_decrypt_short_key();
        apply_setting(3, 1'b1);
        pace_on = 1'b0;
        send_text("QwErT");
    endtask

    task automatic test_column_extremes();
        // zero columns behaves as one
        apply_setting(0, 1'b1);
        send_text("aB!");
        apply_setting(127, 1'b0);
        send_text("cd");
    endtask

    task automatic test_full_and_overflow();
        apply_setting($urandom_range(5, 63), 1'($urandom_range(0, 1)));
        pace_on = 1'b1;
        send_message(rtc_pkg::MAX_LETTERS, 10);
        apply_setting(64, 1'($urandom_range(0, 1)));
        pace_on = 1'b0;
        send_message(rtc_pkg::MAX_LETTERS + 2, 5);
    endtask

    // random keys and messages until the run has sent its share of bytes
    task automatic test_random_messages();
        int cols;
        int eff;
        int sel;
        int n;
        while (bytes_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)
                cols = $urandom_range(1, 6);
            else if (sel == 6)
                cols = $urandom_range(7, 20);
            else if (sel == 7)
                cols = $urandom_range(21, 64);
            else if (sel == 8)
                cols = ($urandom_range(0, 1) != 0) ? 0 : 64;
            else
                cols = $urandom_range(65, 127);
            eff = (cols == 0) ? 1 : cols;
            apply_setting(cols, 1'($urandom_range(0, 1)));
            pace_on = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(2, 5))
            begin
                if (bytes_sent >= ITEM_TARGET)
                    break;
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    n = 0;
                else if (sel <= 2)
                    n = $urandom_range(1, (eff < rtc_pkg::MAX_LETTERS) ? eff
                                                                       : rtc_pkg::MAX_LETTERS);
                else
                    n = eff + 1 + $urandom_range(0, 8);
                if (n > rtc_pkg::MAX_LETTERS)
                    n = rtc_pkg::MAX_LETTERS;
                send_message(n, $urandom_range(0, 30));
                if ($urandom_range(0, 15) == 0)
                    wait_for_results();
            end
        end
    endtask

    // compare every strobed result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result letter %0d last %0b status %0d",
                         $time, out_letter, out_last, status);
                fail_count++;
            end
            else
            begin
                oldest = awaited_results.pop_front();
                results_checked++;
                if (out_letter !== oldest.letter)
                begin
                    $display("%0t: out_letter expected %0d got %0d",
                             $time, oldest.letter, out_letter);
                    fail_count++;
                end
                if (out_last !== oldest.last)
                begin
                    $display("%0t: out_last expected %0b got %0b",
                             $time, oldest.last, out_last);
                    fail_count++;
                end
                if (status !== oldest.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, oldest.status, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or result for %0d cycles", $time, idle_cycles);
            $display("route_transposition_cipher_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_cipher_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_encrypt_mixed_bytes();
        test_decrypt_short_key();
        test_column_extremes();
        test_full_and_overflow();
        test_random_messages();

        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d bytes over %0d key settings, %0d results checked",
                 bytes_sent, settings_used, results_checked);
        $display("messages: %0d ok, %0d empty, %0d too short, %0d overflow",
                 status_tally[rtc_pkg::ST_OK], status_tally[rtc_pkg::ST_EMPTY],
                 status_tally[rtc_pkg::ST_SHORT], status_tally[rtc_pkg::ST_OVERFLOW]);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("route_transposition_cipher_tb: PASS");
        else
            $display("route_transposition_cipher_tb: FAIL");
        $finish;
    end

endmodule
